### hdl/lss_pkg.sv
// lss_pkg: shared constants and sequencer state type for the least-squares slope block
// no dependencies
`default_nettype none

package lss_pkg;

  // point coordinate width, signed q12.4
  localparam int XY_W = 16;
  // slope width and its fraction bits, signed q16.16
  localparam int SLOPE_W = 32;
  localparam int FRAC_W = 16;
  // quotient bits kept below saturation
  localparam int QUOT_W = SLOPE_W - 1;
  // integer quotient bits that fit the slope range
  localparam int SAT_SH = QUOT_W - FRAC_W;

  localparam int MAX_POINTS_DEF = 1024;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_DRAIN,
    ST_LOAD,
    ST_MAC,
    ST_MAG,
    ST_CHK,
    ST_DIV,
    ST_DONE
  } lss_state_e;

endpackage

`default_nettype wire

### hdl/lss_accum.sv
// lss_accum: point counter and running sums of x, y, x*x and x*y
// depends on lss_pkg; one registered multiplier stage ahead of the sum adders
`default_nettype none

module lss_accum
  import lss_pkg::*;
#(
  parameter int MaxPoints = MAX_POINTS_DEF,
  localparam int CntW = $clog2(MaxPoints + 1),
  localparam int SxW = XY_W + CntW,
  localparam int SxxW = 2 * XY_W - 1 + CntW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   take_i,
  input  logic                   clr_i,
  input  logic signed [XY_W-1:0] x_i,
  input  logic signed [XY_W-1:0] y_i,
  output logic [CntW-1:0]        count_o,
  output logic signed [SxW-1:0]  sum_x_o,
  output logic signed [SxW-1:0]  sum_y_o,
  output logic signed [SxxW-1:0] sum_xx_o,
  output logic signed [SxxW-1:0] sum_xy_o,
  output logic                   dropped_o
);

  localparam int ProdW = 2 * XY_W;

  logic [CntW-1:0]         count_q, count_d;
  logic                    dropped_q, dropped_d;
  logic                    add_ok;
  logic                    pv_q;
  logic signed [XY_W-1:0]  px_q, py_q;
  logic signed [ProdW-1:0] pxx_q, pxy_q, pxx_d, pxy_d;
  logic signed [SxW-1:0]   sum_x_q, sum_y_q;
  logic signed [SxxW-1:0]  sum_xx_q, sum_xy_q;

  assign add_ok = count_q < CntW'(MaxPoints);
  assign pxx_d  = ProdW'(x_i) * ProdW'(x_i);
  assign pxy_d  = ProdW'(x_i) * ProdW'(y_i);

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    if (clr_i) begin
      count_d   = '0;
      dropped_d = 1'b0;
    end else if (take_i) begin
      if (add_ok) begin
        count_d = count_q + CntW'(1);
      end else begin
        dropped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      pv_q      <= 1'b0;
      sum_x_q   <= '0;
      sum_y_q   <= '0;
      sum_xx_q  <= '0;
      sum_xy_q  <= '0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
      pv_q      <= take_i && add_ok && !clr_i;
      if (clr_i) begin
        sum_x_q  <= '0;
        sum_y_q  <= '0;
        sum_xx_q <= '0;
        sum_xy_q <= '0;
      end else if (pv_q) begin
        sum_x_q  <= sum_x_q + SxW'(px_q);
        sum_y_q  <= sum_y_q + SxW'(py_q);
        sum_xx_q <= sum_xx_q + SxxW'(pxx_q);
        sum_xy_q <= sum_xy_q + SxxW'(pxy_q);
      end
    end
  end

  // product stage, no reset needed
  always_ff @(posedge clk_i) begin
    px_q  <= x_i;
    py_q  <= y_i;
    pxx_q <= pxx_d;
    pxy_q <= pxy_d;
  end

  assign count_o   = count_q;
  assign sum_x_o   = sum_x_q;
  assign sum_y_o   = sum_y_q;
  assign sum_xx_o  = sum_xx_q;
  assign sum_xy_o  = sum_xy_q;
  assign dropped_o = dropped_q;

endmodule

`default_nettype wire

### hdl/least_squares_slope.sv
// least_squares_slope: least-squares slope of a point set in signed q16.16
// depends on lss_pkg and lss_accum
//
// Usage: points enter on the input channel (x_value_i, y_value_i, last_point_i
// with in_valid_i / in_ready_o), one word per cycle while a set accumulates.
// Up to MaxPoints points are summed; later points of the set are dropped and
// reported through overflowed_o. The word with last_point_i set closes the set
// and in_ready_o drops until its result enters the output register.
// The time from the last point to the result word is set by one shared
// add/subtract unit: four shift-add products of SxW steps each, with
// SxW = 16 + clog2(MaxPoints+1), then a 31-step restoring division; a
// degenerate or saturated set skips the division and finishes sooner.
// The result word (slope_o, degenerate_o, overflowed_o, point_count_o) sits in
// an output register with out_valid_o / out_ready_i. While the receiver stalls
// it is held; the next result waits for it, but points of the next set are
// taken as soon as the sums have been cleared.
// Reset empties the sums, the point count and the output register.
`default_nettype none

module least_squares_slope
  import lss_pkg::*;
#(
  parameter int MaxPoints = MAX_POINTS_DEF,
  localparam int CntW = $clog2(MaxPoints + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [XY_W-1:0]    x_value_i,
  input  logic signed [XY_W-1:0]    y_value_i,
  input  logic                      last_point_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SLOPE_W-1:0] slope_o,
  output logic                      degenerate_o,
  output logic                      overflowed_o,
  output logic [CntW-1:0]           point_count_o
);

  localparam int SxW = XY_W + CntW;
  localparam int SxxW = 2 * XY_W - 1 + CntW;
  localparam int NumW = 2 * CntW + 2 * XY_W;
  localparam int MrW = SxW;
  localparam int StepW = ($clog2(MrW) > $clog2(QUOT_W)) ? $clog2(MrW) : $clog2(QUOT_W);

  lss_state_e state_q, state_d;

  logic                   in_fire, out_fire;
  logic                   clr;
  logic [CntW-1:0]        acc_count;
  logic signed [SxW-1:0]  sum_x, sum_y;
  logic signed [SxxW-1:0] sum_xx, sum_xy;
  logic                   dropped;

  logic [1:0]             prod_q, prod_d;
  logic [StepW-1:0]       step_q, step_d;
  logic [NumW-1:0]        acc_q, acc_d;
  logic [NumW-1:0]        mcand_q, mcand_d;
  logic [MrW-1:0]         mr_q, mr_d;
  logic [NumW-1:0]        num_q, num_d;
  logic [NumW-1:0]        rem_q, rem_d;
  logic [QUOT_W-1:0]      lo_q, lo_d;
  logic [QUOT_W-1:0]      quot_q, quot_d;
  logic                   neg_q, neg_d;
  logic                   sat_q, sat_d;
  logic                   degen_q, degen_d;
  logic                   out_valid_q, out_valid_d;
  logic [SLOPE_W-1:0]     slope_q, slope_d;
  logic                   degen_out_q, ovf_out_q;
  logic [CntW-1:0]        cnt_out_q;

  // shared add/subtract unit
  logic [NumW:0]          alu_a, alu_b, alu_sum;
  logic                   alu_sub;
  logic [NumW-1:0]        mag;
  logic                   mac_last, div_last, den_bad;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_q && out_ready_i;
  assign clr      = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign mac_last = step_q == StepW'(MrW - 1);
  assign div_last = step_q == StepW'(QUOT_W - 1);
  // den lives in acc after the fourth product
  assign den_bad  = (acc_q == '0) || acc_q[NumW-1];
  assign mag      = alu_sum[NumW-1:0];

  lss_accum #(
    .MaxPoints(MaxPoints)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (in_fire),
    .clr_i    (clr),
    .x_i      (x_value_i),
    .y_i      (y_value_i),
    .count_o  (acc_count),
    .sum_x_o  (sum_x),
    .sum_y_o  (sum_y),
    .sum_xx_o (sum_xx),
    .sum_xy_o (sum_xy),
    .dropped_o(dropped)
  );

  assign alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACC:   if (in_fire && last_point_i) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_MAC;
      ST_MAC: begin
        if (mac_last) state_d = (prod_q == 2'd3) ? ST_MAG : ST_LOAD;
      end
      ST_MAG:   state_d = den_bad ? ST_DONE : ST_CHK;
      ST_CHK:   state_d = alu_sum[NumW] ? ST_DIV : ST_DONE;
      ST_DIV:   if (div_last) state_d = ST_DONE;
      ST_DONE:  if (clr) state_d = ST_ACC;
      default:  state_d = ST_ACC;
    endcase
  end

  // datapath and outputs
  always_comb begin
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;
    prod_d      = prod_q;
    step_d      = step_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mr_d        = mr_q;
    num_d       = num_q;
    rem_d       = rem_q;
    lo_d        = lo_q;
    quot_d      = quot_q;
    neg_d       = neg_q;
    sat_d       = sat_q;
    degen_d     = degen_q;
    slope_d     = slope_q;
    out_valid_d = out_fire ? 1'b0 : out_valid_q;
    in_ready_o  = state_q == ST_ACC;

    unique case (state_q)
      ST_ACC:   prod_d = 2'd0;
      ST_DRAIN: prod_d = 2'd0;
      ST_LOAD: begin
        step_d = '0;
        unique case (prod_q)
          2'd0: begin
            acc_d   = '0;
            mcand_d = NumW'(sum_xy);
            mr_d    = MrW'(acc_count);
          end
          2'd1: begin
            mcand_d = NumW'(sum_x);
            mr_d    = MrW'(sum_y);
          end
          2'd2: begin
            num_d   = acc_q;
            acc_d   = '0;
            mcand_d = NumW'(sum_xx);
            mr_d    = MrW'(acc_count);
          end
          default: begin
            mcand_d = NumW'(sum_x);
            mr_d    = MrW'(sum_x);
          end
        endcase
      end
      ST_MAC: begin
        // shift-add; top multiplier bit weighs negative, odd products subtract
        alu_a   = {acc_q[NumW-1], acc_q};
        alu_b   = mr_q[0] ? {mcand_q[NumW-1], mcand_q} : '0;
        alu_sub = prod_q[0] ^ mac_last;
        acc_d   = alu_sum[NumW-1:0];
        mcand_d = mcand_q << 1;
        mr_d    = {mr_q[MrW-1], mr_q[MrW-1:1]};
        step_d  = step_q + StepW'(1);
        if (mac_last) prod_d = prod_q + 2'd1;
      end
      ST_MAG: begin
        alu_b   = {num_q[NumW-1], num_q};
        alu_sub = num_q[NumW-1];
        neg_d   = num_q[NumW-1];
        degen_d = den_bad;
        sat_d   = 1'b0;
        rem_d   = mag >> SAT_SH;
        lo_d    = {mag[SAT_SH-1:0], FRAC_W'(0)};
      end
      ST_CHK: begin
        // integer part too large for the slope range
        alu_a   = {1'b0, rem_q};
        alu_b   = {1'b0, acc_q};
        alu_sub = 1'b1;
        sat_d   = !alu_sum[NumW];
        quot_d  = '0;
        step_d  = '0;
      end
      ST_DIV: begin
        alu_a   = {rem_q, lo_q[QUOT_W-1]};
        alu_b   = {1'b0, acc_q};
        alu_sub = 1'b1;
        rem_d   = alu_sum[NumW] ? alu_a[NumW-1:0] : alu_sum[NumW-1:0];
        lo_d    = lo_q << 1;
        quot_d  = {quot_q[QUOT_W-2:0], !alu_sum[NumW]};
        step_d  = step_q + StepW'(1);
      end
      ST_DONE: begin
        if (clr) begin
          out_valid_d = 1'b1;
          if (degen_q) begin
            slope_d = '0;
          end else if (sat_q) begin
            slope_d = neg_q ? {1'b1, {(SLOPE_W-1){1'b0}}} : {1'b0, {(SLOPE_W-1){1'b1}}};
          end else if (neg_q) begin
            slope_d = SLOPE_W'(0) - {1'b0, quot_q};
          end else begin
            slope_d = {1'b0, quot_q};
          end
        end
      end
      default: begin
        step_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      prod_q      <= 2'd0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prod_q      <= prod_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    mr_q    <= mr_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    lo_q    <= lo_d;
    quot_q  <= quot_d;
    neg_q   <= neg_d;
    sat_q   <= sat_d;
    degen_q <= degen_d;
    slope_q <= slope_d;
    if (clr) begin
      degen_out_q <= degen_q;
      ovf_out_q   <= dropped;
      cnt_out_q   <= acc_count;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign slope_o       = slope_q;
  assign degenerate_o  = degen_out_q;
  assign overflowed_o  = ovf_out_q;
  assign point_count_o = cnt_out_q;

`ifndef SYNTHESIS
  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_point_i) |=> !in_ready_o)
    else $error("input taken after a closing point");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (slope_o == '0))
    else $error("degenerate word with nonzero slope");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_count <= CntW'(MaxPoints))
    else $error("point count beyond capacity");

  a_div_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (!sat_q && !degen_q))
    else $error("division started on saturated or degenerate set");
`endif

endmodule

`default_nettype wire
